// ===== rtl/scrl_pkg.sv =====
// ----------------------------------------------------------------------------
// scrl_pkg
// Shared types and constants of the serial command and reply link: request
// and result codes, frame constants and the item structs of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

package scrl_pkg;

  localparam logic [1:0] REQ_SEND = 2'd0;
  localparam logic [1:0] REQ_RX   = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_REPLY  = 2'd1;
  localparam logic [1:0] KIND_GIVEUP = 2'd2;

  localparam logic [7:0] HDR_BYTE = 8'hAA;

  localparam logic [3:0] LAST_IDX_NORMAL  = 4'd7;
  localparam logic [3:0] LAST_IDX_FACTORY = 4'd11;
  localparam logic [3:0] DATA_IDX_NORMAL  = 4'd3;
  localparam logic [3:0] DATA_IDX_FACTORY = 4'd7;
  localparam logic [3:0] KEY_IDX          = 4'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        factory_mode;
    logic [7:0]  func_code;
    logic [31:0] cmd_data;
    logic [15:0] timeout_ticks;
    logic [7:0]  rx_byte;
  } cmd_in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [7:0]  reply_state;
    logic [31:0] reply_data;
  } link_out_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  state;
    logic [31:0] data;
  } rx_reply_t;

  function automatic logic [7:0] key_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'hFF;
      2'd1:    b = 8'hEE;
      2'd2:    b = 8'hBB;
      default: b = 8'hAA;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/scrl_rx.sv =====
// ----------------------------------------------------------------------------
// scrl_rx
// Reply collector: hunts received bytes for the header, gathers one reply
// and checks its byte sum on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module scrl_rx #(
  parameter int REPLY_BYTES = 7
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 byte_valid_i,
  input  wire logic [7:0]           byte_i,
  output scrl_pkg::rx_reply_t       reply_o
);
  import scrl_pkg::*;

  localparam int CntW = $clog2(REPLY_BYTES);
  localparam logic [CntW-1:0] LastIdx = CntW'(REPLY_BYTES - 1);

  logic            hunting_q, hunting_d;
  logic [CntW-1:0] rx_count_q, rx_count_d;
  logic [7:0]      store_q [REPLY_BYTES];
  logic [7:0]      sum;
  logic [7:0]      rb [7];
  logic            finish;

  always_comb begin
    sum = '0;
    for (int i = 0; i < REPLY_BYTES - 1; i++) begin
      sum = sum + store_q[i];
    end
  end

  for (genvar g = 0; g < 7; g++) begin : g_rb
    if (g < REPLY_BYTES - 1) begin : g_st
      assign rb[g] = store_q[g];
    end else if (g == REPLY_BYTES - 1) begin : g_cur
      assign rb[g] = byte_i;
    end else begin : g_zero
      assign rb[g] = '0;
    end
  end

  assign finish = !hunting_q && (rx_count_q == LastIdx);

  always_comb begin
    hunting_d  = hunting_q;
    rx_count_d = rx_count_q;
    if (byte_valid_i) begin
      priority if (hunting_q) begin
        if (byte_i == HDR_BYTE) begin
          hunting_d  = 1'b0;
          rx_count_d = CntW'(1);
        end
      end else if (finish) begin
        hunting_d  = 1'b1;
        rx_count_d = '0;
      end else begin
        rx_count_d = rx_count_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunting_q  <= 1'b1;
      rx_count_q <= '0;
    end else begin
      hunting_q  <= hunting_d;
      rx_count_q <= rx_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_valid_i) begin
      if (hunting_q) begin
        if (byte_i == HDR_BYTE) begin
          store_q[0] <= byte_i;
        end
      end else if (!finish) begin
        store_q[rx_count_q] <= byte_i;
      end
    end
  end

  assign reply_o.ok    = byte_valid_i && finish && (sum == byte_i);
  assign reply_o.state = rb[2];
  assign reply_o.data  = {rb[5], rb[4], rb[3], rb[2]};

endmodule

`default_nettype wire

// ===== rtl/serial_command_reply_link.sv =====
// ----------------------------------------------------------------------------
// serial_command_reply_link
// Frames commands byte by byte, collects and checks replies, retries on
// timeout. A reply or give-up item is valid the cycle after its input item;
// the first byte of a frame passes the job state, then the output register.
// Throughput: one item per cycle when not stalled; a frame stalls input
// while its 8 or 12 bytes leave the output register one per cycle; output
// stalls hold both. Reset clears all control state; reply store needs none.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_reply_link #(
  parameter int TRY_LIMIT   = 3,
  parameter int REPLY_BYTES = 7
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [7:0]          cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  scrl_pkg::cmd_in_t        in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output scrl_pkg::link_out_t      out_data_o
);
  import scrl_pkg::*;

  localparam logic [1:0] TryLim = 2'(TRY_LIMIT);

  logic [7:0]  dev_addr_q;
  logic        awaiting_q, awaiting_d;
  logic [1:0]  tries_q, tries_d;
  logic [15:0] timer_q, timer_d;
  logic        pend_factory_q, pend_factory_d;
  logic [7:0]  pend_func_q, pend_func_d;
  logic [31:0] pend_data_q, pend_data_d;
  logic [15:0] pend_timeout_q, pend_timeout_d;
  logic        job_active_q, job_active_d;
  logic [3:0]  idx_q, idx_d;
  logic [7:0]  sum_q, sum_d;
  logic        out_valid_q, out_valid_d;
  link_out_t   out_q, out_d;

  logic        accept, is_send, is_rx, tick_live, tick_expire, resend, give_up;
  logic        reply_hit, start_frame, out_free, job_last;
  logic [15:0] timer_dec;
  logic [3:0]  last_idx, data_off;
  logic [7:0]  frame_byte;
  rx_reply_t   rx_reply;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = job_active_q || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_send    = accept && (in_data_i.req_type == REQ_SEND);
  assign is_rx      = accept && (in_data_i.req_type == REQ_RX);
  assign tick_live  = accept && (in_data_i.req_type == REQ_TICK) && awaiting_q;

  scrl_rx #(
    .REPLY_BYTES(REPLY_BYTES)
  ) u_rx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_valid_i(is_rx),
    .byte_i      (in_data_i.rx_byte),
    .reply_o     (rx_reply)
  );

  assign reply_hit   = rx_reply.ok && awaiting_q;
  assign timer_dec   = (timer_q != 16'd0) ? timer_q - 16'd1 : 16'd0;
  assign tick_expire = tick_live && (timer_dec == 16'd0);
  assign resend      = tick_expire && (tries_q < TryLim);
  assign give_up     = tick_expire && !resend;
  assign start_frame = is_send || resend;

  // frame byte selection
  assign last_idx = pend_factory_q ? LAST_IDX_FACTORY : LAST_IDX_NORMAL;
  assign data_off = idx_q - (pend_factory_q ? DATA_IDX_FACTORY : DATA_IDX_NORMAL);
  assign job_last = (idx_q == last_idx);

  always_comb begin
    priority if (idx_q == 4'd0) begin
      frame_byte = HDR_BYTE;
    end else if (idx_q == 4'd1) begin
      frame_byte = dev_addr_q;
    end else if (idx_q == 4'd2) begin
      frame_byte = pend_func_q;
    end else if (job_last) begin
      frame_byte = sum_q;
    end else if (pend_factory_q && (idx_q < DATA_IDX_FACTORY)) begin
      frame_byte = key_byte(2'(idx_q - KEY_IDX));
    end else begin
      frame_byte = pend_data_q[8*data_off[1:0] +: 8];
    end
  end

  always_comb begin
    awaiting_d     = awaiting_q;
    tries_d        = tries_q;
    timer_d        = timer_q;
    pend_factory_d = pend_factory_q;
    pend_func_d    = pend_func_q;
    pend_data_d    = pend_data_q;
    pend_timeout_d = pend_timeout_q;
    job_active_d   = job_active_q;
    idx_d          = idx_q;
    sum_d          = sum_q;
    out_valid_d    = out_valid_q;
    out_d          = out_q;

    if (is_send) begin
      pend_factory_d = in_data_i.factory_mode;
      pend_func_d    = in_data_i.func_code;
      pend_data_d    = in_data_i.cmd_data;
      pend_timeout_d = in_data_i.timeout_ticks;
      tries_d        = 2'd1;
      awaiting_d     = 1'b1;
      timer_d        = (in_data_i.timeout_ticks == 16'd0) ? 16'd1 : in_data_i.timeout_ticks;
    end

    if (tick_live) begin
      timer_d = timer_dec;
    end
    if (resend) begin
      tries_d = tries_q + 2'd1;
      timer_d = (pend_timeout_q == 16'd0) ? 16'd1 : pend_timeout_q;
    end
    if (give_up || reply_hit) begin
      awaiting_d = 1'b0;
    end

    if (start_frame) begin
      job_active_d = 1'b1;
      idx_d        = '0;
      sum_d        = '0;
    end else if (job_active_q && out_free) begin
      idx_d = idx_q + 4'd1;
      sum_d = sum_q + frame_byte;
      if (job_last) begin
        job_active_d = 1'b0;
      end
    end

    priority if (reply_hit) begin
      out_valid_d       = 1'b1;
      out_d.out_kind    = KIND_REPLY;
      out_d.tx_byte     = '0;
      out_d.tx_last     = 1'b0;
      out_d.reply_state = rx_reply.state;
      out_d.reply_data  = rx_reply.data;
    end else if (give_up) begin
      out_valid_d       = 1'b1;
      out_d.out_kind    = KIND_GIVEUP;
      out_d.tx_byte     = '0;
      out_d.tx_last     = 1'b0;
      out_d.reply_state = '0;
      out_d.reply_data  = '0;
    end else if (job_active_q && out_free) begin
      out_valid_d       = 1'b1;
      out_d.out_kind    = KIND_TX;
      out_d.tx_byte     = frame_byte;
      out_d.tx_last     = job_last;
      out_d.reply_state = '0;
      out_d.reply_data  = '0;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q     <= '0;
      awaiting_q     <= 1'b0;
      tries_q        <= '0;
      timer_q        <= '0;
      pend_factory_q <= 1'b0;
      pend_func_q    <= '0;
      pend_data_q    <= '0;
      pend_timeout_q <= '0;
      job_active_q   <= 1'b0;
      idx_q          <= '0;
      sum_q          <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dev_addr_q <= cfg_wdata_i;
      end
      awaiting_q     <= awaiting_d;
      tries_q        <= tries_d;
      timer_q        <= timer_d;
      pend_factory_q <= pend_factory_d;
      pend_func_q    <= pend_func_d;
      pend_data_q    <= pend_data_d;
      pend_timeout_q <= pend_timeout_d;
      job_active_q   <= job_active_d;
      idx_q          <= idx_d;
      sum_q          <= sum_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_job_needs_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_active_q |-> awaiting_q)
    else $error("frame in progress without a pending command");

  a_single_not_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.out_kind != KIND_TX)) |-> !job_active_q)
    else $error("reply or give-up result overlaps a frame");

  a_tries_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> ((tries_q != 2'd0) && (tries_q <= TryLim)))
    else $error("try count out of range while waiting");
`endif

endmodule

`default_nettype wire

// ===== tb/serial_command_reply_link_tb.sv =====
// ----------------------------------------------------------------------------
// serial_command_reply_link_tb
// Self-checking testbench of the serial command and reply link. Commands,
// received bytes and ticks go in with random gaps while the output side stalls
// at random. A scoreboard predicts frames, accepted replies and give-ups and
// checks every output item against them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_command_reply_link_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import scrl_pkg::*;

  localparam int          TRIES      = 3;
  localparam int          REPLY_LEN  = 7;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam logic [31:0] FACTORY_KEY = 32'hFFEEBBAA;
  localparam int          RANDOM_PER_PHASE = 100;
  localparam int          LONG_HOLD  = 300;
  localparam int          LIMIT_NS   = 5_000_000;

  class link_scoreboard;
    logic [7:0]  device_address;
    bit          hunting;
    logic [2:0]  rx_count;
    logic [7:0]  rx_store [7];
    logic [7:0]  pend_func;
    logic [31:0] pend_data;
    bit          pend_factory;
    logic [15:0] pend_timeout;
    logic [15:0] wait_timer;
    logic [1:0]  tries_done;
    bit          awaiting;
    link_out_t   due_outputs[$];
    int          mismatches;

    function new();
      device_address = '0;
      hunting        = 1'b1;
      rx_count       = '0;
      pend_func      = '0;
      pend_data      = '0;
      pend_factory   = 1'b0;
      pend_timeout   = '0;
      wait_timer     = '0;
      tries_done     = '0;
      awaiting       = 1'b0;
      mismatches     = 0;
    endfunction

    function void reload_timer();
      wait_timer = (pend_timeout == 16'd0) ? 16'd1 : pend_timeout;
    endfunction

    function void queue_frame();
      logic [7:0] frame [12];
      logic [7:0] sum;
      link_out_t  r;
      int         n;
      frame[0] = HDR_BYTE;
      frame[1] = device_address;
      frame[2] = pend_func;
      n = 3;
      if (pend_factory) begin
        for (int k = 0; k < 4; k++) begin
          frame[n] = FACTORY_KEY[31 - 8 * k -: 8];
          n = n + 1;
        end
      end
      for (int k = 0; k < 4; k++) begin
        frame[n] = pend_data[8 * k +: 8];
        n = n + 1;
      end
      sum = '0;
      for (int k = 0; k < n; k++) sum = sum + frame[k];
      frame[n] = sum;
      n = n + 1;
      for (int k = 0; k < n; k++) begin
        r = '0;
        r.out_kind = KIND_TX;
        r.tx_byte  = frame[k];
        r.tx_last  = (k == n - 1);
        due_outputs.push_back(r);
      end
    endfunction

    function void take_request(cmd_in_t it);
      link_out_t  r;
      logic [7:0] sum;
      case (it.req_type)
        REQ_SEND: begin
          pend_factory = it.factory_mode;
          pend_func    = it.func_code;
          pend_data    = it.cmd_data;
          pend_timeout = it.timeout_ticks;
          tries_done   = 2'd1;
          awaiting     = 1'b1;
          reload_timer();
          queue_frame();
        end
        REQ_RX: begin
          if (hunting) begin
            if (it.rx_byte == HDR_BYTE) begin
              rx_store[0] = it.rx_byte;
              rx_count    = 3'd1;
              hunting     = 1'b0;
            end
          end else begin
            if (rx_count < 3'd7) rx_store[rx_count] = it.rx_byte;
            rx_count = rx_count + 3'd1;
            if (rx_count >= REPLY_LEN || rx_count == 3'd0) begin
              hunting  = 1'b1;
              rx_count = '0;
              sum = '0;
              for (int k = 0; k < REPLY_LEN - 1; k++) sum = sum + rx_store[k];
              if (sum == rx_store[REPLY_LEN - 1] && awaiting) begin
                awaiting      = 1'b0;
                r             = '0;
                r.out_kind    = KIND_REPLY;
                r.reply_state = rx_store[2];
                r.reply_data  = {rx_store[5], rx_store[4], rx_store[3], rx_store[2]};
                due_outputs.push_back(r);
              end
            end
          end
        end
        REQ_TICK: begin
          if (awaiting) begin
            if (wait_timer != 16'd0) wait_timer = wait_timer - 16'd1;
            if (wait_timer == 16'd0) begin
              if (tries_done < TRIES) begin
                tries_done = tries_done + 2'd1;
                reload_timer();
                queue_frame();
              end else begin
                awaiting   = 1'b0;
                r          = '0;
                r.out_kind = KIND_GIVEUP;
                due_outputs.push_back(r);
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void match_output(link_out_t got);
      link_out_t want;
      if (due_outputs.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: kind %0d tx %02h last %0d state %02h data %08h",
                   got.out_kind, got.tx_byte, got.tx_last, got.reply_state, got.reply_data);
        mismatches++;
      end else begin
        want = due_outputs.pop_front();
        if (got.out_kind !== want.out_kind || got.tx_byte !== want.tx_byte ||
            got.tx_last !== want.tx_last || got.reply_state !== want.reply_state ||
            got.reply_data !== want.reply_data) begin
          if (mismatches < 10)
            $display({"mismatch: expected kind %0d tx %02h last %0d state %02h data %08h,",
                      " got kind %0d tx %02h last %0d state %02h data %08h"},
                     want.out_kind, want.tx_byte, want.tx_last, want.reply_state,
                     want.reply_data, got.out_kind, got.tx_byte, got.tx_last,
                     got.reply_state, got.reply_data);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  cmd_in_t   in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  link_out_t out_data_o;

  link_scoreboard link_model = new();
  int             items_done;
  int             in_run_left;
  int             out_run_left;
  bit             long_hold_req;

  serial_command_reply_link #(
    .TRY_LIMIT  (TRIES),
    .REPLY_BYTES(REPLY_LEN)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // runs of back-to-back items between random waits
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) run_left = $urandom_range(20, 40);
    return $urandom_range(0, 11);
  endfunction

  function automatic cmd_in_t random_of(input logic [1:0] kind);
    cmd_in_t it;
    it.req_type      = kind;
    it.factory_mode  = 1'($urandom_range(0, 1));
    it.func_code     = 8'($urandom_range(0, 255));
    it.cmd_data      = $urandom();
    it.timeout_ticks = 16'($urandom_range(0, 65535));
    it.rx_byte       = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic cmd_in_t make_send(input bit factory, input logic [7:0] func,
                                        input logic [31:0] data, input logic [15:0] ticks);
    cmd_in_t it;
    it               = random_of(REQ_SEND);
    it.factory_mode  = factory;
    it.func_code     = func;
    it.cmd_data      = data;
    it.timeout_ticks = ticks;
    return it;
  endfunction

  function automatic cmd_in_t random_send(input bit short_wait);
    cmd_in_t it;
    it = random_of(REQ_SEND);
    if (short_wait || $urandom_range(0, 1) == 0) it.timeout_ticks = 16'($urandom_range(0, 3));
    return it;
  endfunction

  function automatic cmd_in_t rx_item(input logic [7:0] b);
    cmd_in_t it;
    it         = random_of(REQ_RX);
    it.rx_byte = b;
    return it;
  endfunction

  task automatic drive_item(input cmd_in_t it);
    int gap;
    gap = draw_wait(in_run_left);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    link_model.take_request(it);
    if (it.req_type != REQ_UNUSED) items_done++;
  endtask

  task automatic send_reply(input bit good);
    logic [7:0] bytes [REPLY_LEN];
    logic [7:0] sum;
    bytes[0] = HDR_BYTE;
    sum      = HDR_BYTE;
    for (int k = 1; k < REPLY_LEN - 1; k++) begin
      bytes[k] = ($urandom_range(0, 7) == 0) ? HDR_BYTE : 8'($urandom_range(0, 255));
      sum      = sum + bytes[k];
    end
    bytes[REPLY_LEN - 1] = good ? sum : sum ^ 8'($urandom_range(1, 255));
    for (int k = 0; k < REPLY_LEN; k++) drive_item(rx_item(bytes[k]));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (link_model.due_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_address(input logic [7:0] addr);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= addr;
    @(posedge clk_i);
    link_model.device_address = addr;
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_sequence();
    cmd_in_t it;
    int      n;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      // command answered by a reply, sometimes a corrupted one
      drive_item(random_send(1'b0));
      repeat ($urandom_range(0, 2)) drive_item(random_of(REQ_TICK));
      send_reply($urandom_range(0, 5) != 0);
    end else if (pick < 60) begin
      // command left to run out of tries
      it = random_send(1'b1);
      drive_item(it);
      n = TRIES * ((it.timeout_ticks == 16'd0) ? 1 : int'(it.timeout_ticks))
          + $urandom_range(0, 1);
      repeat (n) drive_item(random_of(REQ_TICK));
    end else if (pick < 70) begin
      send_reply($urandom_range(0, 3) != 0);
    end else if (pick < 80) begin
      // line noise and cut-off replies
      repeat ($urandom_range(1, 6)) begin
        it = random_of(REQ_RX);
        if ($urandom_range(0, 3) == 0) it.rx_byte = HDR_BYTE;
        drive_item(it);
      end
    end else if (pick < 90) begin
      repeat ($urandom_range(2, 3)) drive_item(random_send(1'b1));
      repeat (2) drive_item(random_of(REQ_TICK));
    end else begin
      drive_item(random_of(REQ_TICK));
      drive_item(random_of(REQ_UNUSED));
    end
  endtask

  initial begin : receiver
    int wait_cycles;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        wait_cycles = draw_wait(out_run_left);
        if (wait_cycles > 0) begin
          out_stall_i <= 1'b1;
          repeat (wait_cycles) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      link_model.match_output(out_data_o);
    end
  end

  initial begin : stimulus
    logic [7:0] phase_addr [4];
    int         target;
    items_done    = 0;
    in_run_left   = 0;
    out_run_left  = 0;
    long_hold_req = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_address(8'h00);
    // tick while idle, unused request code
    drive_item(random_of(REQ_TICK));
    drive_item(random_of(REQ_UNUSED));
    // zero timeout: two resends then give up
    drive_item(make_send(1'b0, 8'h00, 32'h0000_0000, 16'h0000));
    repeat (3) drive_item(random_of(REQ_TICK));
    // factory frame, then replaced by a new command
    drive_item(make_send(1'b1, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF));
    drive_item(make_send(1'b0, 8'h5A, 32'h1234_5678, 16'h0001));
    // bad checksum, then a good reply with the header value inside
    foreach (phase_addr[k]) phase_addr[k] = '0;
    drive_item(rx_item(8'hAA));
    drive_item(rx_item(8'h01));
    drive_item(rx_item(8'hAA));
    drive_item(rx_item(8'h34));
    drive_item(rx_item(8'h56));
    drive_item(rx_item(8'h78));
    drive_item(rx_item(8'h58));
    drive_item(rx_item(8'hAA));
    drive_item(rx_item(8'h01));
    drive_item(rx_item(8'hAA));
    drive_item(rx_item(8'h34));
    drive_item(rx_item(8'h56));
    drive_item(rx_item(8'h78));
    drive_item(rx_item(8'h57));

    phase_addr[0] = 8'hFF;
    phase_addr[1] = 8'($urandom_range(0, 255));
    phase_addr[2] = 8'h00;
    phase_addr[3] = 8'($urandom_range(0, 255));
    for (int p = 0; p < 4; p++) begin
      set_address(phase_addr[p]);
      if (p == 1) long_hold_req = 1'b1;
      target = items_done + RANDOM_PER_PHASE;
      while (items_done < target) random_sequence();
    end

    settle();
    if (link_model.mismatches == 0 && link_model.due_outputs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
